// File: hdl/dtq_pkg.sv
// shared widths, codes and defaults of the deadline timer queue
package dtq_pkg;

   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_TIME_BITS   = 32;
   localparam int MAX_RESULTS     = 16;
   localparam int CNT_W           = $clog2(MAX_RESULTS + 1);

   localparam int REQ_W    = 2;
   localparam int VALUE_W  = 32;
   localparam int HANDLE_W = 8;
   localparam int KIND_W   = 2;

   typedef enum logic [REQ_W-1:0] {
      REQ_ADD_REL = 2'd0,
      REQ_ADD_ABS = 2'd1,
      REQ_ADVANCE = 2'd2,
      REQ_UNUSED  = 2'd3
   } req_code_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACCEPTED = 2'd0,
      KIND_REPLACED = 2'd1,
      KIND_REJECTED = 2'd2,
      KIND_FIRED    = 2'd3
   } kind_type;

endpackage

// File: hdl/deadline_timer_queue.sv
// deadline timer queue: time counter, timer table in memory, sequencer and result register
//
// usage
//   request words: pulse start with req_type, req_time_value and req_handle while busy is
//   low; the word is taken at that edge and busy rises on the next cycle.
//   add (relative or absolute): the table is scanned once for a timer with the same
//   deadline and for the first free slot, then one status word comes out with rsp_last set.
//   advance: the time counter moves forward (saturating), then the table is scanned
//   repeatedly; each scan picks the earliest due timer, which fires as one response word.
//   at most MAX_RESULTS fire per advance; the last one carries rsp_last. nothing due means
//   no response word. request type 3 is dropped without a response.
//   response words: rsp_strobe marks each word for exactly one cycle; the receiver cannot
//   hold them off, so the block never waits on the response side.
// timing
//   one scan reads the table memory one entry per cycle through its single read port
//   and ends in a decision cycle; the response word appears in the cycle after its
//   decision cycle. a new request is taken once busy is low.
// reset
//   synchronous, active high: time counter to zero, all slots free, no response pending.
//   deadline and handle storage is not cleared, slots are gated by their valid bits.
module deadline_timer_queue #(
   parameter int QUEUE_DEPTH = dtq_pkg::DEF_QUEUE_DEPTH,
   parameter int TIME_BITS   = dtq_pkg::DEF_TIME_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [dtq_pkg::REQ_W-1:0]     req_type,
   input  logic [dtq_pkg::VALUE_W-1:0]   req_time_value,
   input  logic [dtq_pkg::HANDLE_W-1:0]  req_handle,
   output logic                          rsp_strobe,
   output logic [dtq_pkg::KIND_W-1:0]    rsp_kind,
   output logic [dtq_pkg::HANDLE_W-1:0]  rsp_fired_handle,
   output logic [dtq_pkg::VALUE_W-1:0]   rsp_fired_deadline,
   output logic                          rsp_last
);
   import dtq_pkg::*;

   localparam int IDX_W  = $clog2(QUEUE_DEPTH);
   localparam int ADDR_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [TIME_BITS-1:0] TIME_MAX  = '1;
   localparam logic [IDX_W-1:0]     LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [ADDR_W-1:0]    ADDR_END  = ADDR_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0]     CNT_LIMIT = CNT_W'(MAX_RESULTS);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EVAL = 3'b100
   } state_type;

   // timer table: deadline and handle memories, one read and one write port each
   logic [TIME_BITS-1:0] mem_deadline [QUEUE_DEPTH];
   logic [HANDLE_W-1:0]  mem_handle   [QUEUE_DEPTH];

   // sequencer and per-slot valid bits
   state_type            state_ff, state_in;
   logic [QUEUE_DEPTH-1:0] valid_ff, valid_in;
   logic [TIME_BITS-1:0] cur_ff, cur_in;
   logic                 is_add_ff, is_add_in;
   logic [TIME_BITS-1:0] dl_ff, dl_in;
   logic [HANDLE_W-1:0]  hnd_ff, hnd_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;

   // read data pipeline, registered behind the address
   logic                 chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]     chk_idx_ff, chk_idx_in;
   logic [TIME_BITS-1:0] rd_dl_ff;
   logic [HANDLE_W-1:0]  rd_hnd_ff;
   logic                 rd_en;

   // search results of the running scan
   logic                 same_found_ff, same_found_in;
   logic [IDX_W-1:0]     same_idx_ff, same_idx_in;
   logic                 free_found_ff, free_found_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;
   logic                 best_found_ff, best_found_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [TIME_BITS-1:0] best_dl_ff, best_dl_in;
   logic [HANDLE_W-1:0]  best_hnd_ff, best_hnd_in;

   // fired timer held back until the next scan tells whether it is the last one
   logic                 pend_ff, pend_in;
   logic [TIME_BITS-1:0] pend_dl_ff, pend_dl_in;
   logic [HANDLE_W-1:0]  pend_hnd_ff, pend_hnd_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   // table write port
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_wa;

   // response register
   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [KIND_W-1:0]    rsp_kind_ff, rsp_kind_in;
   logic [HANDLE_W-1:0]  rsp_hnd_ff, rsp_hnd_in;
   logic [TIME_BITS-1:0] rsp_dl_ff, rsp_dl_in;
   logic                 rsp_last_ff, rsp_last_in;

   // saturating time arithmetic on the incoming value
   logic [TIME_BITS+VALUE_W-1:0] tv_ext;
   logic [TIME_BITS-1:0]         tv_sat;
   logic [TIME_BITS:0]           tv_sum;
   logic [TIME_BITS-1:0]         tv_sum_sat;
   logic [TIME_BITS+VALUE_W-1:0] rsp_dl_ext;
   logic                         take_more;

   assign tv_ext     = {{TIME_BITS{1'b0}}, req_time_value};
   assign tv_sat     = (|tv_ext[TIME_BITS+VALUE_W-1:TIME_BITS]) ? TIME_MAX
                                                                 : tv_ext[TIME_BITS-1:0];
   assign tv_sum     = {1'b0, cur_ff} + {1'b0, tv_sat};
   assign tv_sum_sat = tv_sum[TIME_BITS] ? TIME_MAX : tv_sum[TIME_BITS-1:0];

   // another timer fires in this advance only if one was found and the budget allows
   assign take_more  = best_found_ff && (cnt_ff != CNT_LIMIT);

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      cur_in        = cur_ff;
      is_add_in     = is_add_ff;
      dl_in         = dl_ff;
      hnd_in        = hnd_ff;
      addr_in       = addr_ff;
      chk_valid_in  = 1'b0;
      chk_idx_in    = chk_idx_ff;
      rd_en         = 1'b0;
      same_found_in = same_found_ff;
      same_idx_in   = same_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_dl_in    = best_dl_ff;
      best_hnd_in   = best_hnd_ff;
      pend_in       = pend_ff;
      pend_dl_in    = pend_dl_ff;
      pend_hnd_in   = pend_hnd_ff;
      cnt_in        = cnt_ff;
      mem_we        = 1'b0;
      mem_wa        = same_idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_hnd_in    = rsp_hnd_ff;
      rsp_dl_in     = rsp_dl_ff;
      rsp_last_in   = rsp_last_ff;

      // compare the entry read in the previous cycle
      if (chk_valid_ff) begin
         if (valid_ff[chk_idx_ff]) begin
            if (!same_found_ff && rd_dl_ff == dl_ff) begin
               same_found_in = 1'b1;
               same_idx_in   = chk_idx_ff;
            end
            if (rd_dl_ff <= cur_ff && (!best_found_ff || rd_dl_ff < best_dl_ff)) begin
               best_found_in = 1'b1;
               best_idx_in   = chk_idx_ff;
               best_dl_in    = rd_dl_ff;
               best_hnd_in   = rd_hnd_ff;
            end
         end else if (!free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = chk_idx_ff;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               same_found_in = 1'b0;
               free_found_in = 1'b0;
               best_found_in = 1'b0;
               addr_in       = '0;
               hnd_in        = req_handle;
               unique case (req_type)
                  REQ_ADD_REL: begin
                     is_add_in = 1'b1;
                     dl_in     = tv_sum_sat;
                     state_in  = ST_SCAN;
                  end
                  REQ_ADD_ABS: begin
                     is_add_in = 1'b1;
                     dl_in     = tv_sat;
                     state_in  = ST_SCAN;
                  end
                  REQ_ADVANCE: begin
                     is_add_in = 1'b0;
                     cur_in    = tv_sum_sat;
                     cnt_in    = '0;
                     pend_in   = 1'b0;
                     state_in  = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (addr_ff != ADDR_END) begin
               rd_en        = 1'b1;
               chk_valid_in = 1'b1;
               chk_idx_in   = addr_ff[IDX_W-1:0];
               addr_in      = addr_ff + 1'b1;
            end
            if (chk_valid_ff && chk_idx_ff == LAST_IDX) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (is_add_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_hnd_in    = hnd_ff;
               rsp_dl_in     = dl_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
               if (same_found_ff) begin
                  mem_we      = 1'b1;
                  mem_wa      = same_idx_ff;
                  rsp_kind_in = KIND_REPLACED;
               end else if (free_found_ff) begin
                  mem_we                = 1'b1;
                  mem_wa                = free_idx_ff;
                  valid_in[free_idx_ff] = 1'b1;
                  rsp_kind_in           = KIND_ACCEPTED;
               end else begin
                  rsp_kind_in = KIND_REJECTED;
               end
            end else begin
               if (pend_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_kind_in   = KIND_FIRED;
                  rsp_hnd_in    = pend_hnd_ff;
                  rsp_dl_in     = pend_dl_ff;
                  rsp_last_in   = !take_more;
               end
               if (take_more) begin
                  pend_in               = 1'b1;
                  pend_dl_in            = best_dl_ff;
                  pend_hnd_in           = best_hnd_ff;
                  valid_in[best_idx_ff] = 1'b0;
                  cnt_in                = cnt_ff + 1'b1;
                  same_found_in         = 1'b0;
                  free_found_in         = 1'b0;
                  best_found_in         = 1'b0;
                  addr_in               = '0;
                  state_in              = ST_SCAN;
               end else begin
                  pend_in  = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // table memory: registered read, write only in the decision cycle, so a scan never
   // overlaps a write to the same entry
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_dl_ff  <= mem_deadline[addr_ff[IDX_W-1:0]];
         rd_hnd_ff <= mem_handle[addr_ff[IDX_W-1:0]];
      end
      if (mem_we) begin
         mem_deadline[mem_wa] <= dl_ff;
         mem_handle[mem_wa]   <= hnd_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         cur_ff        <= '0;
         chk_valid_ff  <= 1'b0;
         same_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
         best_found_ff <= 1'b0;
         pend_ff       <= 1'b0;
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         cur_ff        <= cur_in;
         chk_valid_ff  <= chk_valid_in;
         same_found_ff <= same_found_in;
         free_found_ff <= free_found_in;
         best_found_ff <= best_found_in;
         pend_ff       <= pend_in;
         cnt_ff        <= cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      is_add_ff   <= is_add_in;
      dl_ff       <= dl_in;
      hnd_ff      <= hnd_in;
      addr_ff     <= addr_in;
      chk_idx_ff  <= chk_idx_in;
      same_idx_ff <= same_idx_in;
      free_idx_ff <= free_idx_in;
      best_idx_ff <= best_idx_in;
      best_dl_ff  <= best_dl_in;
      best_hnd_ff <= best_hnd_in;
      pend_dl_ff  <= pend_dl_in;
      pend_hnd_ff <= pend_hnd_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_hnd_ff  <= rsp_hnd_in;
      rsp_dl_ff   <= rsp_dl_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_dl_ext         = {{VALUE_W{1'b0}}, rsp_dl_ff};
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_fired_handle   = rsp_hnd_ff;
   assign rsp_fired_deadline = rsp_dl_ext[VALUE_W-1:0];
   assign rsp_last           = rsp_last_ff;

   // status words of adds always close their request
   a_add_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_kind_ff != KIND_FIRED |-> rsp_last_ff)
      else $error("add status word without last");

   // a fired timer is never later than the time counter
   a_fire_due: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_kind_ff == KIND_FIRED |-> rsp_dl_ff <= cur_ff)
      else $error("fired timer not yet due");

   // no read data in flight once the sequencer is idle
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !chk_valid_ff && !pend_ff)
      else $error("scan activity while idle");

   // fire budget per advance
   a_cnt_limit: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_LIMIT)
      else $error("fire count beyond limit");

   // a response word never comes before the request is finished or a rescan begins
   a_rsp_after_eval: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff) == ST_EVAL)
      else $error("response word outside decision cycle");

endmodule
